FILE: hw/rtl/lpdah_pkg.sv
// package for the leading pair azimuth histogrammer
// constants, types and the arctangent table; no dependencies
package lpdah_pkg;

   localparam int NumBinsDefault     = 50;
   localparam int CordicStepsDefault = 16;
   localparam int AtanEntries        = 24;
   localparam int CordW              = 36;

   localparam logic OP_JET  = 1'b0;
   localparam logic OP_READ = 1'b1;
   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [23:0] jet_energy;
      logic signed [23:0] mom_x;
      logic signed [23:0] mom_y;
      logic        last_jet;
      logic        which_histogram;
      logic [5:0]  bin_index;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic signed [15:0] phi_lead;
      logic signed [15:0] phi_second;
      logic signed [15:0] delta_phi;
      logic [31:0] bin_count;
   } rsp_type;

   // command handed from the front to the back
   typedef struct packed {
      logic        is_read;
      logic        which_histogram;
      logic [5:0]  bin_index;
      logic signed [23:0] lead_x;
      logic signed [23:0] lead_y;
      logic signed [23:0] second_x;
      logic signed [23:0] second_y;
   } cmd_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41721;
            5'd15: r = 32'd20860;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2607;
            5'd19: r = 32'd1303;
            5'd20: r = 32'd651;
            5'd21: r = 32'd325;
            5'd22: r = 32'd162;
            5'd23: r = 32'd81;
            default: r = 32'd0;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: hw/rtl/lpdah_stream_if.sv
// valid/ready channel carrying one payload word
// depends on nothing
interface lpdah_stream_if #(parameter int W = 8) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/lpdah_front.sv
// front: keeps the two most energetic jets and issues commands
// depends on lpdah_pkg
module lpdah_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lpdah_pkg::req_type   in_word,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output lpdah_pkg::cmd_type   cmd_word
);
   import lpdah_pkg::*;

   logic [23:0] lead_e_ff, lead_e_in, sec_e_ff, sec_e_in;
   logic [47:0] lead_m_ff, lead_m_in, sec_m_ff, sec_m_in;
   logic [1:0]  seen_ff, seen_in;
   logic        fire;

   // a word is taken only when the queue can take its command
   assign in_ready = cmd_ready;
   assign fire = in_valid && in_ready;

   always_comb begin
      lead_e_in = lead_e_ff; lead_m_in = lead_m_ff;
      sec_e_in  = sec_e_ff;  sec_m_in  = sec_m_ff;
      seen_in   = seen_ff;
      cmd_valid = 1'b0;
      cmd_word  = '0;
      if (fire) begin
         if (in_word.opcode == OP_READ) begin
            cmd_valid = 1'b1;
            cmd_word.is_read = 1'b1;
            cmd_word.which_histogram = in_word.which_histogram;
            cmd_word.bin_index = in_word.bin_index;
         end else begin
            if (seen_ff == 2'd0) begin
               lead_e_in = in_word.jet_energy;
               lead_m_in = {in_word.mom_y, in_word.mom_x};
            end else if (in_word.jet_energy > lead_e_ff) begin
               sec_e_in = lead_e_ff; sec_m_in = lead_m_ff;
               lead_e_in = in_word.jet_energy;
               lead_m_in = {in_word.mom_y, in_word.mom_x};
            end else if (seen_ff == 2'd1 || in_word.jet_energy > sec_e_ff) begin
               sec_e_in = in_word.jet_energy;
               sec_m_in = {in_word.mom_y, in_word.mom_x};
            end
            if (seen_ff != 2'd2) seen_in = seen_ff + 2'd1;
            if (in_word.last_jet) begin
               cmd_valid = (seen_in == 2'd2);
               cmd_word.lead_x   = lead_m_in[23:0];
               cmd_word.lead_y   = lead_m_in[47:24];
               cmd_word.second_x = sec_m_in[23:0];
               cmd_word.second_y = sec_m_in[47:24];
               lead_e_in = '0; lead_m_in = '0;
               sec_e_in  = '0; sec_m_in  = '0;
               seen_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_e_ff <= '0; lead_m_ff <= '0;
         sec_e_ff  <= '0; sec_m_ff  <= '0;
         seen_ff   <= '0;
      end else begin
         lead_e_ff <= lead_e_in; lead_m_ff <= lead_m_in;
         sec_e_ff  <= sec_e_in;  sec_m_ff  <= sec_m_in;
         seen_ff   <= seen_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) seen_ff != 2'd3)
      else $error("jet count out of range");
   assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> fire)
      else $error("command without accepted word");
   assert property (@(posedge clock) disable iff (reset)
      fire && in_word.opcode == OP_JET && in_word.last_jet |=> seen_ff == 2'd0)
      else $error("event state not cleared");
endmodule

FILE: hw/rtl/lpdah_queue.sv
// short command queue between front and back
// depends on lpdah_pkg
module lpdah_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  lpdah_pkg::cmd_type wr_word,
   output logic               rd_valid,
   input  logic               rd_ready,
   output lpdah_pkg::cmd_type rd_word
);
   import lpdah_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_word  = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_word;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count lost a push");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) == (wp_ff != rp_ff))
      else $error("queue pointers disagree with count");
endmodule

FILE: hw/rtl/lpdah_back.sv
// back: cordic atan2 for both jets, histogram fill and bin read
// also holds the generic registered-read ram used for the histograms
// depends on lpdah_pkg
module lpdah_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
endmodule

module lpdah_back #(
   parameter int NUM_BINS     = lpdah_pkg::NumBinsDefault,
   parameter int CORDIC_STEPS = lpdah_pkg::CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  lpdah_pkg::cmd_type cmd_word,
   output logic               out_valid,
   input  logic               out_ready,
   output lpdah_pkg::rsp_type out_word
);
   import lpdah_pkg::*;

   localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_ROT, S_NEXT, S_BIN, S_FILL, S_OUT, S_RD
   } state_type;

   state_type   state_ff;
   cmd_type     cmd_ff;
   logic signed [CordW-1:0] x_ff, y_ff;
   logic [31:0] z_ff;
   logic [4:0]  step_ff;
   logic        jet_ff;
   logic [15:0] a1_ff, a2_ff;
   logic [1:0]  fill_ff;
   logic [BW-1:0] idx_ff, clr_ff;
   logic [BW-1:0] bin_ff;
   logic        bin_ok_ff;
   rsp_type     out_ff;
   logic        out_v_ff;

   logic signed [23:0] vx, vy;
   logic signed [CordW-1:0] sx, sy;
   logic [15:0] ang, fill_ang, dlt;
   logic [15:0] flipped;
   logic [16+BW:0] prod;
   logic [15:0] z_round;
   logic          phi_we, dlt_we;
   logic [BW-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_data, phi_rd, dlt_rd, fill_rd;

   assign cmd_ready = (state_ff == S_IDLE) && !out_v_ff;
   assign out_valid = out_v_ff;
   assign out_word  = out_ff;

   assign vx = jet_ff ? cmd_ff.second_x : cmd_ff.lead_x;
   assign vy = jet_ff ? cmd_ff.second_y : cmd_ff.lead_y;
   assign sx = x_ff >>> step_ff;
   assign sy = y_ff >>> step_ff;
   assign z_round = 16'((z_ff + 32'h8000) >> 16);
   assign dlt = a1_ff - a2_ff;
   assign fill_ang = (fill_ff == 2'd0) ? a1_ff : ((fill_ff == 2'd1) ? a2_ff : dlt);
   assign flipped = fill_ang ^ 16'h8000;
   assign prod = (17 + BW)'(flipped) * (17 + BW)'(NUM_BINS);
   assign ang = z_round;

   // histogram ram ports
   assign rd_addr = (state_ff == S_IDLE) ? BW'(cmd_word.bin_index) : BW'(prod >> 16);
   assign fill_rd = (fill_ff == 2'd2) ? dlt_rd : phi_rd;
   assign wr_addr = (state_ff == S_CLEAR) ? clr_ff : idx_ff;
   assign wr_data = (state_ff == S_CLEAR) ? 32'd0 : fill_rd + 32'd1;
   assign phi_we  = (state_ff == S_CLEAR) ||
                    (state_ff == S_FILL && bin_ok_ff && fill_ff != 2'd2 &&
                     phi_rd != 32'hFFFF_FFFF);
   assign dlt_we  = (state_ff == S_CLEAR) ||
                    (state_ff == S_FILL && bin_ok_ff && fill_ff == 2'd2 &&
                     dlt_rd != 32'hFFFF_FFFF);

   lpdah_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_phi_ram (
      .clock, .wr_en(phi_we), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(phi_rd)
   );

   lpdah_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_dlt_ram (
      .clock, .wr_en(dlt_we), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(dlt_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (out_v_ff && out_ready) out_v_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == NUM_BINS - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  cmd_ff <= cmd_word;
                  if (cmd_word.is_read) begin
                     bin_ok_ff <= 32'(cmd_word.bin_index) < NUM_BINS;
                     state_ff <= S_RD;
                  end else begin
                     jet_ff <= 1'b0;
                     state_ff <= S_NEXT;
                  end
               end
            end
            S_RD: begin
               out_ff <= '{result_kind: KIND_READ, phi_lead: 16'd0, phi_second: 16'd0,
                           delta_phi: 16'd0,
                           bin_count: bin_ok_ff ? (cmd_ff.which_histogram ? dlt_rd : phi_rd)
                                                : 32'd0};
               out_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_NEXT: begin
               // load a vector, pre-rotate left half plane by pi
               step_ff <= '0;
               if (vx < 0) begin
                  x_ff <= CordW'(-(CordW'(vx))) <<< 8;
                  y_ff <= CordW'(-(CordW'(vy))) <<< 8;
                  z_ff <= 32'h8000_0000;
               end else begin
                  x_ff <= CordW'(vx) <<< 8;
                  y_ff <= CordW'(vy) <<< 8;
                  z_ff <= '0;
               end
               state_ff <= S_ROT;
            end
            S_ROT: begin
               if (32'(step_ff) < CORDIC_STEPS && 32'(step_ff) < AtanEntries) begin
                  if (y_ff >= 0) begin
                     x_ff <= x_ff + sy; y_ff <= y_ff - sx;
                     z_ff <= z_ff + atan_entry(step_ff);
                  end else begin
                     x_ff <= x_ff - sy; y_ff <= y_ff + sx;
                     z_ff <= z_ff - atan_entry(step_ff);
                  end
                  step_ff <= step_ff + 5'd1;
               end else begin
                  if (!jet_ff) begin
                     a1_ff <= (vx == 0 && vy == 0) ? 16'd0 : ang;
                     jet_ff <= 1'b1;
                     state_ff <= S_NEXT;
                  end else begin
                     a2_ff <= (vx == 0 && vy == 0) ? 16'd0 : ang;
                     fill_ff <= '0;
                     state_ff <= S_BIN;
                  end
               end
            end
            S_BIN: begin
               idx_ff <= BW'(prod >> 16);
               bin_ok_ff <= 32'(prod >> 16) < NUM_BINS;
               state_ff <= S_FILL;
            end
            S_FILL: begin
               if (fill_ff == 2'd2) state_ff <= S_OUT;
               else begin
                  fill_ff <= fill_ff + 2'd1;
                  state_ff <= S_BIN;
               end
            end
            S_OUT: begin
               out_ff <= '{result_kind: KIND_EVENT, phi_lead: a1_ff, phi_second: a2_ff,
                           delta_phi: dlt, bin_count: 32'd0};
               out_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign bin_ff = idx_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> !out_v_ff)
      else $error("command taken with result pending");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> fill_ff <= 2'd2)
      else $error("fill counter out of range");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL && bin_ok_ff |-> 32'(bin_ff) < NUM_BINS)
      else $error("bin index beyond histogram");
endmodule

FILE: hw/rtl/leading_pair_delta_angle_histogram.sv
// channel | dir | payload
// req     | in  | opcode, jet_energy, mom_x, mom_y, last_jet, which_histogram, bin_index
// rsp     | out | result_kind, phi_lead, phi_second, delta_phi, bin_count
// jets are taken by the front while the queue has room; an event holds the back while
// the one shared cordic unit works both jets in turn; a read holds it for the bin read
// after reset the back clears NUM_BINS histogram rows, one a cycle, before serving
// a two-word queue lets the front keep taking jets while the back works
// depends on lpdah_pkg, lpdah_stream_if, lpdah_front, lpdah_queue, lpdah_back
module leading_pair_delta_angle_histogram #(
   parameter int NUM_BINS     = lpdah_pkg::NumBinsDefault,
   parameter int CORDIC_STEPS = lpdah_pkg::CordicStepsDefault
) (
   input  logic       clock,
   input  logic       reset,
   lpdah_stream_if.sink   req,
   lpdah_stream_if.source rsp
);
   import lpdah_pkg::*;

   logic    f_valid, f_ready, q_valid, q_ready;
   cmd_type f_word, q_word;
   req_type req_word;
   rsp_type rsp_word;

   assign req_word = req.data;
   assign rsp.data = rsp_word;

   lpdah_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_word(req_word),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_word(f_word)
   );

   lpdah_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_word(f_word),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_word(q_word)
   );

   lpdah_back #(.NUM_BINS(NUM_BINS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_word(q_word),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_word(rsp_word)
   );
endmodule

FILE: test/tb_top.sv
// self-checking testbench for leading_pair_delta_angle_histogram
// drives jets and bin reads over req, checks angles and counts on rsp
// depends on lpdah_pkg, lpdah_stream_if and the block itself
`timescale 1ns / 1ps

module tb_top;
   import lpdah_pkg::*;

   localparam int NBins = 50;
   localparam int Steps = 16;

   class angle_scoreboard;
      logic [23:0] lead_e, second_e;
      logic [47:0] lead_m, second_m;
      int unsigned jets;
      logic [31:0] phi_hist[NBins];
      logic [31:0] dphi_hist[NBins];
      rsp_type expected_words[$];
      int unsigned mismatches;
      int unsigned events_done, reads_done;
      logic [31:0] atan_lut[24];

      function new();
         atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41721, 20860, 10430, 5215,
                      2607, 1303, 651, 325, 162, 81};
         clear_event();
         for (int i = 0; i < NBins; i++) begin
            phi_hist[i] = '0;
            dphi_hist[i] = '0;
         end
         mismatches = 0;
      endfunction

      function void clear_event();
         lead_e = '0;
         second_e = '0;
         lead_m = '0;
         second_m = '0;
         jets = 0;
      endfunction

      function logic [15:0] azimuth(logic [47:0] m);
         longint x, y, dx, dy;
         logic [31:0] z, zr;
         x = longint'($signed(m[23:0]));
         y = longint'($signed(m[47:24]));
         z = '0;
         if (x == 0 && y == 0) return 16'h0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
         end
         x = x * 256;
         y = y * 256;
         for (int i = 0; i < Steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               z = z + atan_lut[i];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - atan_lut[i];
            end
         end
         zr = z + 32'h8000;
         return zr[31:16];
      endfunction

      function void bump(ref logic [31:0] h[NBins], input logic [15:0] a);
         logic [31:0] idx;
         idx = ({16'h0, a ^ 16'h8000} * 32'd50) >> 16;
         if (idx < NBins && h[idx] != 32'hFFFF_FFFF) h[idx] = h[idx] + 1;
      endfunction

      function void note_input(req_type r);
         rsp_type e;
         logic [47:0] m;
         logic [15:0] a1, a2;
         e = '0;
         if (r.opcode == OP_READ) begin
            e.result_kind = KIND_READ;
            if (r.bin_index < NBins)
               e.bin_count = r.which_histogram ? dphi_hist[r.bin_index]
                                               : phi_hist[r.bin_index];
            expected_words.push_back(e);
            reads_done++;
            return;
         end
         m = {r.mom_y, r.mom_x};
         if (jets == 0) begin
            lead_e = r.jet_energy;
            lead_m = m;
         end else if (r.jet_energy > lead_e) begin
            second_e = lead_e;
            second_m = lead_m;
            lead_e = r.jet_energy;
            lead_m = m;
         end else if (jets == 1 || r.jet_energy > second_e) begin
            second_e = r.jet_energy;
            second_m = m;
         end
         if (jets < 2) jets++;
         if (!r.last_jet) return;
         if (jets < 2) begin
            clear_event();
            return;
         end
         a1 = azimuth(lead_m);
         a2 = azimuth(second_m);
         e.result_kind = KIND_EVENT;
         e.phi_lead = a1;
         e.phi_second = a2;
         e.delta_phi = a1 - a2;
         bump(phi_hist, a1);
         bump(phi_hist, a2);
         bump(dphi_hist, a1 - a2);
         clear_event();
         expected_words.push_back(e);
         events_done++;
      endfunction

      function void check(rsp_type got);
         rsp_type e;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
            return;
         end
         e = expected_words.pop_front();
         if (got.result_kind !== e.result_kind || got.phi_lead !== e.phi_lead ||
             got.phi_second !== e.phi_second || got.delta_phi !== e.delta_phi ||
             got.bin_count !== e.bin_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch kind %0d/%0d lead %0d/%0d second %0d/%0d dphi %0d/%0d count %0d/%0d",
                        e.result_kind, got.result_kind, e.phi_lead, got.phi_lead,
                        e.phi_second, got.phi_second, e.delta_phi, got.delta_phi,
                        e.bin_count, got.bin_count);
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   lpdah_stream_if #(.W($bits(req_type))) req_ch (clock);
   lpdah_stream_if #(.W($bits(rsp_type))) rsp_ch (clock);

   leading_pair_delta_angle_histogram i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   angle_scoreboard sb = new();
   bit quiet = 0;
   bit hold_request = 0;
   int unsigned hold_left = 0;
   int unsigned items_sent = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   // receiver side: check accepted words, then choose ready
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check(rsp_type'(rsp_ch.data));
      if (hold_request && hold_left == 0) hold_left <= 400;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      if (reset || hold_left > 1 || (hold_request && hold_left == 0)) rsp_ch.ready <= 1'b0;
      else if (quiet) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(99) >= 38);
   end

   task automatic send(req_type r);
      int unsigned gap;
      if (!quiet && $urandom_range(99) < 38) begin
         gap = $urandom_range(6, 1);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_input(r);
      items_sent++;
   endtask

   function automatic req_type jet(logic [23:0] e, logic [23:0] x, logic [23:0] y,
                                   logic last);
      req_type r;
      r = '0;
      r.opcode = OP_JET;
      r.jet_energy = e;
      r.mom_x = x;
      r.mom_y = y;
      r.last_jet = last;
      r.which_histogram = 1'($urandom_range(1));
      r.bin_index = 6'($urandom_range(63));
      return r;
   endfunction

   function automatic req_type bin_read(logic which, logic [5:0] idx);
      req_type r;
      r = '0;
      r.opcode = OP_READ;
      r.which_histogram = which;
      r.bin_index = idx;
      r.jet_energy = 24'($urandom);
      r.mom_x = 24'($urandom);
      r.mom_y = 24'($urandom);
      r.last_jet = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic random_event();
      int unsigned n;
      logic [23:0] e, x, y;
      n = $urandom_range(5, 1);
      for (int j = 0; j < n; j++) begin
         case ($urandom_range(3))
            0: e = 24'($urandom_range(7));
            default: e = 24'($urandom);
         endcase
         x = ($urandom_range(9) == 0) ? 24'h0 : 24'($urandom);
         y = ($urandom_range(9) == 0) ? 24'h0 : 24'($urandom);
         if ($urandom_range(7) == 0) begin
            x = x >>> 16;
            y = y >>> 16;
         end
         send(jet(e, x, y, j == n - 1));
         if ($urandom_range(19) == 0)
            send(bin_read(1'($urandom_range(1)), 6'($urandom_range(63))));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero vector, negative x, ties, lone jet, reads
      send(jet(24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0));
      send(jet(24'h000000, 24'h800000, 24'h800000, 1'b1));
      send(jet(24'd10, 24'h0, 24'h0, 1'b0));
      send(jet(24'd10, 24'hFFFFFF, 24'h0, 1'b1));
      send(jet(24'd5, 24'h800000, 24'h000001, 1'b0));
      send(bin_read(1'b0, 6'd25));
      send(jet(24'd9, 24'h000100, 24'hFFFF00, 1'b1));
      send(jet(24'd77, 24'h001000, 24'h002000, 1'b1));
      send(jet(24'd1, 24'h7FFFFF, 24'h800000, 1'b0));
      send(jet(24'd2, 24'h000000, 24'h7FFFFF, 1'b0));
      send(jet(24'd3, 24'h800000, 24'h000000, 1'b0));
      send(jet(24'd2, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
      send(jet(24'd4, 24'hFFF000, 24'h000000, 1'b0));
      send(jet(24'd4, 24'hFFF000, 24'hFFFFFF, 1'b1));
      for (int b = 0; b < 2; b++) begin
         send(bin_read(1'(b), 6'd0));
         send(bin_read(1'(b), 6'd49));
         send(bin_read(1'(b), 6'd50));
         send(bin_read(1'(b), 6'd63));
         send(bin_read(1'(b), 6'd24));
      end

      while (items_sent < 900) begin
         if (items_sent > 300 && items_sent < 460) quiet = 1;
         else quiet = 0;
         if (items_sent > 500 && items_sent < 520 && !hold_request) hold_request = 1;
         if (items_sent > 560) hold_request = 0;
         if (items_sent > 700 && items_sent < 712) begin
            req_ch.valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         if ($urandom_range(9) == 0)
            send(bin_read(1'($urandom_range(1)), 6'($urandom_range(63))));
         else random_event();
      end
      hold_request = 0;
      for (int i = 0; i < 64; i++) send(bin_read(i[0], i[6:1]));
      req_ch.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d words: %0d two-jet events and %0d bin reads checked",
               items_sent, sb.events_done, sb.reads_done);
      $display("%0d mismatches", sb.mismatches);
      if (sb.mismatches == 0) $display("leading_pair_delta_angle_histogram test passed");
      else $display("leading_pair_delta_angle_histogram test failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("leading_pair_delta_angle_histogram test failed");
      $finish;
   end

endmodule

FILE: leading_pair_delta_angle_histogram.f
hw/rtl/lpdah_pkg.sv
hw/rtl/lpdah_stream_if.sv
hw/rtl/lpdah_front.sv
hw/rtl/lpdah_queue.sv
hw/rtl/lpdah_back.sv
hw/rtl/leading_pair_delta_angle_histogram.sv
test/tb_top.sv
